// File: hdl/emrs_pkg.sv
// Shared types and constants for the extent map read splitter.
// No dependencies; emrs_ctrl, emrs_dp and the top level import this package.
package emrs_pkg;

  localparam int MAX_EXTENTS_DEF = 32;
  localparam int RESULT_LIMIT    = 32;
  localparam int K_W             = $clog2(RESULT_LIMIT);
  localparam int ADDR_W          = 48;
  localparam int LEN_W           = 32;
  localparam int BLK_W           = 39;
  localparam int BCNT_W          = 24;
  localparam int SKIP_W          = 16;
  localparam int SH_W            = 5;
  localparam int SH_MIN          = 9;
  localparam int SH_MAX          = 16;
  localparam int SH_RESET        = 12;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 48;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILE_SIZE   = 1'b0,
    CFG_BLOCK_SHIFT = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_APPEND,
    ST_CLIP1,
    ST_CLIP2,
    ST_FETCH,
    ST_LOCATE,
    ST_CHUNK,
    ST_CALC,
    ST_EMIT,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [ADDR_W-1:0] dev_start;
    logic [LEN_W-1:0]  ext_length;
    logic [ADDR_W-1:0] rd_offset;
    logic [LEN_W-1:0]  read_len;
  } req_t;

  typedef struct packed {
    logic              chunk_valid;
    logic [BLK_W-1:0]  first_block;
    logic [BCNT_W-1:0] block_count;
    logic [SKIP_W-1:0] skip_bytes;
    logic [LEN_W-1:0]  copy_bytes;
    logic [LEN_W-1:0]  dest_offset;
    logic [LEN_W-1:0]  total_bytes;
    logic              status;
    logic              last;
  } rsp_t;

  typedef struct packed {
    logic latch;
    logic clear;
    logic append;
    logic clip1;
    logic clip2;
    logic loc_step;
    logic chunk;
    logic calc;
    logic load_piece;
    logic load_rsp;
  } cmd_t;

  typedef struct packed {
    logic walk_end;
    logic loc_skip;
    logic piece_last;
  } sts_t;

endpackage

// File: hdl/emrs_req_if.sv
// Request channel of the extent map read splitter: valid/ready plus one item.
// Depends on nothing; widths match emrs_pkg.
interface emrs_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [47:0] dev_start;
  logic [31:0] ext_length;
  logic [47:0] rd_offset;
  logic [31:0] read_len;

  modport source (output valid, opcode, dev_start, ext_length, rd_offset, read_len,
                  input ready);
  modport sink   (input valid, opcode, dev_start, ext_length, rd_offset, read_len,
                  output ready);
endinterface

// File: hdl/emrs_rsp_if.sv
// Result channel of the extent map read splitter: valid/ready plus one result.
// Depends on nothing; widths match emrs_pkg.
interface emrs_rsp_if;
  logic        valid;
  logic        ready;
  logic        chunk_valid;
  logic [38:0] first_block;
  logic [23:0] block_count;
  logic [15:0] skip_bytes;
  logic [31:0] copy_bytes;
  logic [31:0] dest_offset;
  logic [31:0] total_bytes;
  logic        status;
  logic        last;

  modport source (output valid, chunk_valid, first_block, block_count, skip_bytes,
                  copy_bytes, dest_offset, total_bytes, status, last,
                  input ready);
  modport sink   (input valid, chunk_valid, first_block, block_count, skip_bytes,
                  copy_bytes, dest_offset, total_bytes, status, last,
                  output ready);
endinterface

// File: hdl/emrs_ctrl.sv
// Controller of the extent map read splitter: sequences append, clear and the
// read walk over the extent table. Depends on emrs_pkg.
module emrs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic [1:0]    req_opcode,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output emrs_pkg::cmd_t cmd,
  input  emrs_pkg::sts_t sts
);
  import emrs_pkg::*;

  state_t state, state_next;
  logic   locating, locating_next;
  logic   out_free;

  assign out_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      locating  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state    <= state_next;
      locating <= locating_next;
      if (cmd.load_piece || cmd.load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next    = state;
    locating_next = locating;
    cmd           = '0;
    req_ready     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.latch = 1'b1;
          unique case (req_opcode)
            OP_APPEND: state_next = ST_APPEND;
            OP_READ:   state_next = ST_CLIP1;
            OP_CLEAR: begin
              cmd.clear  = 1'b1;
              state_next = ST_RESP;
            end
            default:   state_next = ST_RESP;
          endcase
        end
      end
      ST_APPEND: begin
        cmd.append = 1'b1;
        state_next = ST_RESP;
      end
      ST_CLIP1: begin
        cmd.clip1  = 1'b1;
        state_next = ST_CLIP2;
      end
      ST_CLIP2: begin
        cmd.clip2     = 1'b1;
        locating_next = 1'b1;
        state_next    = ST_FETCH;
      end
      // table entry is read during this state
      ST_FETCH: begin
        if (sts.walk_end) begin
          state_next = ST_RESP;
        end else if (locating) begin
          state_next = ST_LOCATE;
        end else begin
          state_next = ST_CHUNK;
        end
      end
      ST_LOCATE: begin
        if (sts.loc_skip) begin
          cmd.loc_step = 1'b1;
          state_next   = ST_FETCH;
        end else begin
          locating_next = 1'b0;
          state_next    = ST_CHUNK;
        end
      end
      ST_CHUNK: begin
        cmd.chunk  = 1'b1;
        state_next = ST_CALC;
      end
      ST_CALC: begin
        cmd.calc   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.load_piece = 1'b1;
          state_next     = sts.piece_last ? ST_IDLE : ST_FETCH;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          cmd.load_rsp = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: hdl/emrs_dp.sv
// Datapath of the extent map read splitter: config registers, extent table
// memory, read clipping, piece arithmetic and the result register. Depends on emrs_pkg.
module emrs_dp #(
  parameter int MAX_EXTENTS = emrs_pkg::MAX_EXTENTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [emrs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [emrs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  emrs_pkg::req_t                   req_data,
  output emrs_pkg::rsp_t                   rsp_data,
  input  emrs_pkg::cmd_t                   cmd,
  output emrs_pkg::sts_t                   sts
);
  import emrs_pkg::*;

  localparam int CNT_W = $clog2(MAX_EXTENTS + 1);
  localparam int IDX_W = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [LEN_W-1:0]  size;
  } ext_t;

  ext_t mem [MAX_EXTENTS];
  ext_t q;

  logic [ADDR_W-1:0] file_size;
  logic [SH_W-1:0]   block_shift;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  idx;
  logic [K_W-1:0]    k;

  logic [ADDR_W-1:0] dev_start_r;
  logic [LEN_W-1:0]  ext_len_r;
  logic [ADDR_W-1:0] off;
  logic [LEN_W-1:0]  len;
  logic [ADDR_W-1:0] diff;
  logic              past;
  logic [LEN_W-1:0]  remain;
  logic [LEN_W-1:0]  done;
  logic [LEN_W-1:0]  dest;
  logic [LEN_W-1:0]  chunk;
  logic [ADDR_W-1:0] dev;
  logic [LEN_W:0]    cnt_sum;
  logic              st;

  logic [SH_W-1:0]   sh;
  logic [SKIP_W-1:0] bmask;
  logic [SKIP_W-1:0] skip;
  logic [LEN_W-1:0]  avail;
  logic [LEN_W-1:0]  chunk_next;
  logic [LEN_W-1:0]  remain_clip;
  logic [CNT_W:0]    idx_inc;
  logic              has_room;

  // clamp the block shift to the supported block sizes
  always_comb begin
    if (block_shift < SH_W'(SH_MIN)) begin
      sh = SH_W'(SH_MIN);
    end else if (block_shift > SH_W'(SH_MAX)) begin
      sh = SH_W'(SH_MAX);
    end else begin
      sh = block_shift;
    end
  end

  assign bmask    = SKIP_W'((17'd1 << sh) - 17'd1);
  assign skip     = dev[SKIP_W-1:0] & bmask;
  assign avail    = q.size - off[LEN_W-1:0];
  assign chunk_next = (avail > remain) ? remain : avail;
  assign remain_clip = past ? '0 :
                       ((diff > {{(ADDR_W-LEN_W){1'b0}}, len}) ? len : diff[LEN_W-1:0]);
  assign idx_inc  = {1'b0, idx} + (CNT_W+1)'(1);
  assign has_room = count < CNT_W'(MAX_EXTENTS);

  assign sts.walk_end   = (remain == '0) || (idx >= count);
  assign sts.loc_skip   = off >= {{(ADDR_W-LEN_W){1'b0}}, q.size};
  assign sts.piece_last = (remain == '0) || (idx_inc >= {1'b0, count}) ||
                          (k == K_W'(RESULT_LIMIT - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      file_size   <= '0;
      block_shift <= SH_W'(SH_RESET);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FILE_SIZE:   file_size   <= cfg_data[ADDR_W-1:0];
        CFG_BLOCK_SHIFT: block_shift <= cfg_data[SH_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.append && ext_len_r != '0 && has_room) begin
      count <= count + CNT_W'(1);
    end
  end

  // extent table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.append && ext_len_r != '0 && has_room) begin
      mem[count[IDX_W-1:0]] <= '{base: dev_start_r, size: ext_len_r};
    end
    q <= mem[idx[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      dev_start_r <= req_data.dev_start;
      ext_len_r   <= req_data.ext_length;
      off         <= req_data.rd_offset;
      len         <= req_data.read_len;
      st          <= 1'b0;
    end
    if (cmd.append) begin
      st <= (ext_len_r != '0) && !has_room;
    end
    if (cmd.clip1) begin
      diff <= file_size - off;
      past <= off >= file_size;
    end
    if (cmd.clip2) begin
      remain <= remain_clip;
      idx    <= '0;
      k      <= '0;
      done   <= '0;
    end
    // skip whole extents that lie before the start offset
    if (cmd.loc_step) begin
      off <= off - {{(ADDR_W-LEN_W){1'b0}}, q.size};
      idx <= idx_inc[CNT_W-1:0];
    end
    if (cmd.chunk) begin
      chunk <= chunk_next;
      dev   <= q.base + off;
    end
    if (cmd.calc) begin
      remain  <= remain - chunk;
      dest    <= done;
      done    <= done + chunk;
      cnt_sum <= (LEN_W+1)'(skip) + (LEN_W+1)'(chunk) + (LEN_W+1)'(bmask);
    end
    if (cmd.load_piece) begin
      rsp_data.chunk_valid <= 1'b1;
      rsp_data.first_block <= BLK_W'(dev >> sh);
      rsp_data.block_count <= BCNT_W'(cnt_sum >> sh);
      rsp_data.skip_bytes  <= skip;
      rsp_data.copy_bytes  <= chunk;
      rsp_data.dest_offset <= dest;
      rsp_data.total_bytes <= sts.piece_last ? done : '0;
      rsp_data.status      <= 1'b0;
      rsp_data.last        <= sts.piece_last;
      idx <= idx_inc[CNT_W-1:0];
      k   <= k + K_W'(1);
      off <= '0;
    end
    if (cmd.load_rsp) begin
      rsp_data <= '{chunk_valid: 1'b0,
                    first_block: '0,
                    block_count: '0,
                    skip_bytes:  '0,
                    copy_bytes:  '0,
                    dest_offset: '0,
                    total_bytes: '0,
                    status:      st,
                    last:        1'b1};
    end
  end

endmodule

// File: hdl/extent_map_read_splitter.sv
// Extent map read splitter. An append, a clear or a reserved opcode is accepted
// and leads to a single result in the output register. A read is sequenced over
// the extent table: setup (accept, then two steps to clip the length), a test of
// the start extent, a table read and test for each extent skipped before the
// start offset, and for each emitted piece a table read, chunk size, block
// arithmetic and load. A read is bounded by the table depth MAX_EXTENTS and 32
// pieces; a result that waits for ready stalls the walk. One item is worked at
// a time; a new item is taken while the last result still waits in the output
// register.
// Configuration is a plain write port and must only be written while idle.
// Depends on emrs_pkg, emrs_req_if, emrs_rsp_if, emrs_ctrl and emrs_dp.
module extent_map_read_splitter #(
  parameter int MAX_EXTENTS = emrs_pkg::MAX_EXTENTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [emrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [emrs_pkg::CFG_DATA_W-1:0] cfg_data,
  emrs_req_if.sink                        req,
  emrs_rsp_if.source                      rsp
);
  import emrs_pkg::*;

  cmd_t cmd;
  sts_t sts;
  req_t req_data;
  rsp_t rsp_data;

  assign req_data = '{opcode:      req.opcode,
                      dev_start:   req.dev_start,
                      ext_length:  req.ext_length,
                      rd_offset:   req.rd_offset,
                      read_len:    req.read_len};

  assign rsp.chunk_valid = rsp_data.chunk_valid;
  assign rsp.first_block = rsp_data.first_block;
  assign rsp.block_count = rsp_data.block_count;
  assign rsp.skip_bytes  = rsp_data.skip_bytes;
  assign rsp.copy_bytes  = rsp_data.copy_bytes;
  assign rsp.dest_offset = rsp_data.dest_offset;
  assign rsp.total_bytes = rsp_data.total_bytes;
  assign rsp.status      = rsp_data.status;
  assign rsp.last        = rsp_data.last;

  emrs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_opcode (req.opcode),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .cmd        (cmd),
    .sts        (sts)
  );

  emrs_dp #(
    .MAX_EXTENTS (MAX_EXTENTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_data  (req_data),
    .rsp_data  (rsp_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// File: hdl/emrs_checker.sv
// Port-level checks for the extent map read splitter, bound to the top level.
// Depends only on the top level's ports.
module emrs_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        rsp_chunk_valid,
  input logic [31:0] rsp_copy_bytes,
  input logic [31:0] rsp_total_bytes,
  input logic        rsp_status,
  input logic        rsp_last
);

  // a result that is not a piece is always marked last
  a_single_non_piece: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_chunk_valid |-> rsp_last)
    else $error("non-piece result without last");

  a_total_on_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_last |-> rsp_total_bytes == 32'd0)
    else $error("total bytes set before the last beat");

  a_piece_sane: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_chunk_valid |-> rsp_copy_bytes != 32'd0 && rsp_status == 1'b0)
    else $error("piece with zero copy length or nonzero status");

  // ready always drops right after an item is accepted
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken on back-to-back cycles");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_last))
    else $error("stalled result beat dropped or changed");

endmodule

bind extent_map_read_splitter emrs_checker u_emrs_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_chunk_valid (rsp.chunk_valid),
  .rsp_copy_bytes  (rsp.copy_bytes),
  .rsp_total_bytes (rsp.total_bytes),
  .rsp_status      (rsp.status),
  .rsp_last        (rsp.last)
);
